>>> rtl/hcsl_pkg.sv
// Shared types, constants and helpers for the chunk-size line parser.
// No dependencies; used by hcsl_step and http_chunk_size_line_parser.
`default_nettype none
package hcsl_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TOTAL_WIDTH = 48;
  localparam int SIZE_WIDTH  = 31;
  localparam int BYTE_WIDTH  = 8;
  localparam int STAT_WIDTH  = 2;
  // status travels on tuser; tdata carries the remaining result fields
  localparam int OUT_BITS    = SIZE_WIDTH + 2 * COUNT_WIDTH + TOTAL_WIDTH;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  localparam logic [BYTE_WIDTH-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_WIDTH-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_WIDTH-1:0] CH_SEMI = 8'h3B;
  localparam logic [BYTE_WIDTH-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_WIDTH-1:0] CH_TAB  = 8'h09;

  // result status codes
  localparam logic [STAT_WIDTH-1:0] ST_DATA  = 2'd0;
  localparam logic [STAT_WIDTH-1:0] ST_TRAIL = 2'd1;
  localparam logic [STAT_WIDTH-1:0] ST_ERROR = 2'd2;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_DIGITS = 3'd1,
    PH_BLANKS = 3'd2,
    PH_CR     = 3'd3,
    PH_EXT    = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [SIZE_WIDTH-1:0]   acc;
    logic [COUNT_WIDTH-1:0]  byte_count;
    logic [TOTAL_WIDTH-1:0]  total;
  } parse_state_t;

  typedef struct packed {
    logic [STAT_WIDTH-1:0]   status;
    logic [SIZE_WIDTH-1:0]   chunk_size;
    logic [COUNT_WIDTH-1:0]  line_length;
    logic [COUNT_WIDTH-1:0]  error_offset;
    logic [TOTAL_WIDTH-1:0]  body_total;
  } result_t;

  // bit 4 set when the byte is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_digit(input logic [BYTE_WIDTH-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hcsl_step.sv
// One-byte state transition of the chunk-size line parser (combinational).
// Depends on hcsl_pkg.
`default_nettype none
module hcsl_step (
  input  wire  logic [hcsl_pkg::BYTE_WIDTH-1:0] data_byte,
  input  wire  hcsl_pkg::parse_state_t          cur,
  output hcsl_pkg::parse_state_t                nxt,
  output logic                                  res_valid,
  output hcsl_pkg::result_t                     res
);

  logic [4:0]                         hex;
  logic                               blank;
  logic [hcsl_pkg::COUNT_WIDTH-1:0]   cnt_inc;
  logic [hcsl_pkg::TOTAL_WIDTH:0]     sum_wide;
  logic                               do_done;
  logic                               do_err;
  logic [hcsl_pkg::COUNT_WIDTH-1:0]   err_off;
  logic                               term;

  always_comb begin
    hex     = hcsl_pkg::hex_digit(data_byte);
    blank   = (data_byte == hcsl_pkg::CH_SP) || (data_byte == hcsl_pkg::CH_TAB);
    cnt_inc = (cur.byte_count == hcsl_pkg::COUNT_MAX) ? cur.byte_count
                                                      : cur.byte_count + 1'b1;
    sum_wide = {1'b0, cur.total}
             + {{(hcsl_pkg::TOTAL_WIDTH + 1 - hcsl_pkg::SIZE_WIDTH){1'b0}}, cur.acc};
    nxt     = cur;
    do_done = 1'b0;
    do_err  = 1'b0;
    err_off = cur.byte_count;
    term    = 1'b0;

    case (cur.phase)
      hcsl_pkg::PH_FIRST, hcsl_pkg::PH_DIGITS: begin
        if (hex[4]) begin
          // any of the top four size bits set: next shift would overflow
          if (|cur.acc[hcsl_pkg::SIZE_WIDTH-1:hcsl_pkg::SIZE_WIDTH-4]) begin
            do_err  = 1'b1;
            err_off = cnt_inc;
          end else begin
            nxt.acc        = {cur.acc[hcsl_pkg::SIZE_WIDTH-5:0], hex[3:0]};
            nxt.phase      = hcsl_pkg::PH_DIGITS;
            nxt.byte_count = cnt_inc;
          end
        end else if (cur.phase == hcsl_pkg::PH_FIRST) begin
          do_err  = 1'b1;
          err_off = '0;
        end else begin
          term = 1'b1;
        end
      end
      hcsl_pkg::PH_BLANKS: term = 1'b1;
      hcsl_pkg::PH_CR: begin
        if (data_byte == hcsl_pkg::CH_LF) begin
          do_done = 1'b1;
        end else begin
          do_err = 1'b1;
        end
      end
      hcsl_pkg::PH_EXT: begin
        if (data_byte == hcsl_pkg::CH_LF) begin
          do_done = 1'b1;
        end else begin
          if (data_byte == hcsl_pkg::CH_CR) nxt.phase = hcsl_pkg::PH_CR;
          nxt.byte_count = cnt_inc;
        end
      end
      default: begin
        nxt.phase      = hcsl_pkg::PH_FIRST;
        nxt.acc        = '0;
        nxt.byte_count = '0;
      end
    endcase

    // blanks, terminators and extension start after the digits
    if (term) begin
      if (blank) begin
        nxt.phase      = hcsl_pkg::PH_BLANKS;
        nxt.byte_count = cnt_inc;
      end else if (data_byte == hcsl_pkg::CH_LF) begin
        do_done = 1'b1;
      end else if (data_byte == hcsl_pkg::CH_CR) begin
        nxt.phase      = hcsl_pkg::PH_CR;
        nxt.byte_count = cnt_inc;
      end else if (data_byte == hcsl_pkg::CH_SEMI) begin
        nxt.phase      = hcsl_pkg::PH_EXT;
        nxt.byte_count = cnt_inc;
      end else begin
        do_err = 1'b1;
      end
    end

    res_valid        = do_done || do_err;
    res.status       = hcsl_pkg::ST_ERROR;
    res.chunk_size   = '0;
    res.line_length  = '0;
    res.error_offset = err_off;
    res.body_total   = cur.total;

    if (do_done) begin
      nxt.total = sum_wide[hcsl_pkg::TOTAL_WIDTH] ? hcsl_pkg::TOTAL_MAX
                                                  : sum_wide[hcsl_pkg::TOTAL_WIDTH-1:0];
      res.status       = (cur.acc != '0) ? hcsl_pkg::ST_DATA : hcsl_pkg::ST_TRAIL;
      res.chunk_size   = cur.acc;
      res.line_length  = cnt_inc;
      res.error_offset = '0;
      res.body_total   = nxt.total;
    end

    if (res_valid) begin
      nxt.phase      = hcsl_pkg::PH_FIRST;
      nxt.acc        = '0;
      nxt.byte_count = '0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/http_chunk_size_line_parser.sv
// Top level of the HTTP/1.1 chunk-size line parser: input register, parse state,
// output register with skid entry. Depends on hcsl_pkg and hcsl_step.
//
//   channel | dir | beat                 | tuser bits  | tdata bits (low to high)
//   s_*     | in  | one line byte        | -           | data_byte[7:0]
//   m_*     | out | one result per line  | status[1:0] | chunk_size[30:0]
//           |     |   or per error       |             | line_length[46:31]
//           |     |                      |             | error_offset[62:47]
//           |     |                      |             | body_total[110:63], zero pad [111]
//
// Throughput is one byte per cycle while s_tready is high; the final byte of a line sits
// in the input register, then its result is registered into the result register (or the
// skid entry behind a held result), and m_tvalid is driven from the result register.
// The per-byte step is a small phase decode plus a 4-bit shift-in and one 49-bit
// saturating add, all between the input register and the result register.
// rst (synchronous) clears the parse phase, size, byte count and body total.
// A stalled m_tready parks one result in the skid entry; s_tready drops only while
// the input register is full and the skid entry is occupied.
`default_nettype none
module http_chunk_size_line_parser (
  input  wire  logic                                clk,
  input  wire  logic                                rst,
  input  wire  logic                                s_tvalid,
  output logic                                      s_tready,
  input  wire  logic [hcsl_pkg::BYTE_WIDTH-1:0]     s_tdata,   // data_byte[7:0]
  output logic                                      m_tvalid,
  input  wire  logic                                m_tready,
  output logic [hcsl_pkg::STAT_WIDTH-1:0]           m_tuser,   // status[1:0]
  // chunk_size, line_length, error_offset, body_total, zero pad
  output logic [hcsl_pkg::OUT_TDATA_W-1:0]          m_tdata
);

  // input register
  logic                              s1_valid;
  logic [hcsl_pkg::BYTE_WIDTH-1:0]   s1_byte;
  logic                              s1_fire;

  // parse state
  hcsl_pkg::parse_state_t            state;
  hcsl_pkg::parse_state_t            state_next;
  logic                              res_valid;
  hcsl_pkg::result_t                 res;

  // result register and skid entry
  logic                              out_valid;
  hcsl_pkg::result_t                 out_res;
  logic                              skid_valid;
  hcsl_pkg::result_t                 skid_res;
  logic                              push;
  logic                              pop;

  hcsl_step u_step (
    .data_byte (s1_byte),
    .cur       (state),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  // the step may run whenever a free result slot is guaranteed
  assign s1_fire  = s1_valid && !skid_valid;
  assign s_tready = !s1_valid || !skid_valid;
  assign push     = s1_fire && res_valid;
  assign pop      = out_valid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {{(hcsl_pkg::OUT_TDATA_W - hcsl_pkg::OUT_BITS){1'b0}},
                     out_res.body_total, out_res.error_offset, out_res.line_length,
                     out_res.chunk_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) s1_byte <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= hcsl_pkg::PH_FIRST;
      state.acc        <= '0;
      state.byte_count <= '0;
      state.total      <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || (pop && !skid_valid)) begin
          out_valid <= 1'b1;
          out_res   <= res;
        end else if (pop) begin
          // skid moves up, new result parks behind it
          out_res    <= skid_res;
          skid_res   <= res;
        end else begin
          skid_valid <= 1'b1;
          skid_res   <= res;
        end
      end else if (pop) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // skid entry is only used behind a held result
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry occupied with empty result register");

  // an error result never carries a size or a length
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status == hcsl_pkg::ST_ERROR) |->
      (out_res.chunk_size == '0 && out_res.line_length == '0))
    else $error("error result with nonzero size or length");

  // every emitted result sends the parser back to its start phase
  a_restart: assert property (@(posedge clk) disable iff (rst)
    push |=> (state.phase == hcsl_pkg::PH_FIRST && state.byte_count == '0))
    else $error("parser did not restart after a result");

  // running body total only grows
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (state.total >= $past(state.total)))
    else $error("body total decreased");

endmodule
`default_nettype wire
